FILE: hdl/lcsi_pkg.sv
// Shared constants, codes and beat types of the label counting-sort index.
`default_nettype none

package lcsi_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_LABELS   = 64;

	localparam int KIND_W   = 2;
	localparam int LABEL_W  = $clog2(MAX_LABELS);
	localparam int POS_W    = $clog2(MAX_VERTICES);
	localparam int CNT_W    = POS_W + 1;
	localparam int OFS_AW   = $clog2(MAX_LABELS + 1);
	localparam int LCNT_W   = 7;
	localparam int STATUS_W = 2;

	localparam logic [LCNT_W-1:0] LCNT_RESET = LCNT_W'(64);

	localparam logic [KIND_W-1:0] KIND_LOAD        = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BUILD       = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ_ENTRY  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ_START  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LABEL_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_BUILT   = 2'd3;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_LOAD_BAD,
		OP_BUILD,
		OP_READ_ENTRY,
		OP_READ_START,
		OP_READ_START_BAD
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [LABEL_W-1:0] label;
		logic [POS_W-1:0]   position;
	} lcsi_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    vertex_id;
		logic [CNT_W-1:0]    label_start;
		logic [CNT_W-1:0]    vertex_total;
	} lcsi_result_t;

endpackage

`default_nettype wire

FILE: hdl/lcsi_front.sv
// Front end: label count register, input beat acceptance and classification.
`default_nettype none

module lcsi_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [lcsi_pkg::KIND_W-1:0]  kind,
	input  logic [lcsi_pkg::LABEL_W-1:0] label,
	input  logic [lcsi_pkg::POS_W-1:0]   position,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lcsi_pkg::LCNT_W-1:0]  label_count,
	output logic                         push_valid,
	input  logic                         push_ready,
	output lcsi_pkg::lcsi_item_t         push_item
);
	import lcsi_pkg::*;

	logic [LCNT_W-1:0] label_count_q;
	logic [LCNT_W-1:0] lim;
	logic [LCNT_W-1:0] label_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= LCNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			label_count_q <= label_count;
		end
	end

	// clamp the register to the label space
	assign lim       = (label_count_q > LCNT_W'(MAX_LABELS)) ? LCNT_W'(MAX_LABELS)
	                                                         : label_count_q;
	assign label_ext = LCNT_W'(label);

	always_comb begin
		push_item.label    = label;
		push_item.position = position;
		case (kind)
			KIND_LOAD: begin
				push_item.op = (label_ext >= lim) ? OP_LOAD_BAD : OP_LOAD;
			end
			KIND_BUILD: begin
				push_item.op = OP_BUILD;
			end
			KIND_READ_ENTRY: begin
				push_item.op = OP_READ_ENTRY;
			end
			KIND_READ_START: begin
				push_item.op = (label_ext > lim) ? OP_READ_START_BAD : OP_READ_START;
			end
			default: begin
				push_item.op = OP_BUILD;
			end
		endcase
	end

	assign push_valid = item_valid;
	assign item_stall = !push_ready;

endmodule

`default_nettype wire

FILE: hdl/lcsi_queue.sv
// Two-entry queue of classified beats between front and back end.
`default_nettype none

module lcsi_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  lcsi_pkg::lcsi_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output lcsi_pkg::lcsi_item_t pop_item
);
	import lcsi_pkg::*;

	localparam int DEPTH  = 2;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	lcsi_item_t        entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	logic              pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/lcsi_back.sv
// Back end: histogram, prefix sweep, scatter pipeline, lookups and result register.
`default_nettype none

module lcsi_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  lcsi_pkg::lcsi_item_t   pop_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output lcsi_pkg::lcsi_result_t result
);
	import lcsi_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_READ,
		S_PREFIX,
		S_SCATTER
	} state_t;

	localparam int PF_LAST = MAX_LABELS + 1;
	localparam int PF_W    = $clog2(PF_LAST + 2);

	// storage
	logic [LABEL_W-1:0] label_store_mem [MAX_VERTICES];
	logic [CNT_W-1:0]   hist_mem        [MAX_LABELS];
	logic [CNT_W-1:0]   ofs_mem         [MAX_LABELS + 1];
	logic [CNT_W-1:0]   cursor_mem      [MAX_LABELS];
	logic [POS_W-1:0]   sorted_mem      [MAX_VERTICES];
	logic [MAX_LABELS-1:0] hist_vld_q;

	logic [LABEL_W-1:0] ls_rd_q;
	logic [CNT_W-1:0]   hist_rd_q;
	logic [CNT_W-1:0]   ofs_rd_q;
	logic [CNT_W-1:0]   cur_rd_q;
	logic [POS_W-1:0]   sorted_rd_q;

	// control and working registers
	state_t             state_q;
	state_t             next_state;
	op_t                op_q;
	logic [LABEL_W-1:0] lab_q;
	logic [CNT_W-1:0]   count_q;
	logic               built_q;
	logic [PF_W-1:0]    pf_idx_q;
	logic [CNT_W-1:0]   run_q;
	logic [CNT_W-1:0]   sc_idx_q;
	logic               vld_s1;
	logic [POS_W-1:0]   id_s1;
	logic               vld_s2;
	logic [POS_W-1:0]   id_s2;
	logic [LABEL_W-1:0] lab_s2;
	logic               fwd_vld_q;
	logic [LABEL_W-1:0] fwd_lab_q;
	logic [CNT_W-1:0]   fwd_val_q;
	logic               out_vld_q;
	lcsi_result_t       out_res_q;

	// combinational control
	logic               out_free;
	logic               take;
	logic               emit;
	lcsi_result_t       emit_res;
	logic               clear_set;
	logic               load_we;
	logic               set_built;
	logic [CNT_W-1:0]   hist_new;
	logic               hist_re;
	logic [LABEL_W-1:0] hist_raddr;
	logic               ofs_re;
	logic               ofs_we;
	logic [OFS_AW-1:0]  ofs_waddr;
	logic               cursor_re;
	logic               cursor_we;
	logic [LABEL_W-1:0] cursor_waddr;
	logic [CNT_W-1:0]   cursor_wdata;
	logic               sorted_re;
	logic               sorted_we;
	logic               ls_re;
	logic [PF_W-1:0]    pf_prev;
	logic               pf_data;
	logic [CNT_W-1:0]   pf_h;
	logic [CNT_W-1:0]   slot;

	assign out_free = !out_vld_q || !result_stall;
	assign pop_ready = (state_q == S_IDLE) && out_free;
	assign take = pop_valid && pop_ready;

	assign hist_new = (hist_vld_q[lab_q] ? hist_rd_q : '0) + CNT_W'(1);

	assign pf_prev = pf_idx_q - PF_W'(1);
	assign pf_data = (pf_idx_q != '0) && (pf_idx_q <= PF_W'(MAX_LABELS));
	assign pf_h    = hist_vld_q[pf_prev[LABEL_W-1:0]] ? hist_rd_q : '0;

	// a cursor written last cycle is not yet visible in the read data
	assign slot = (fwd_vld_q && (fwd_lab_q == lab_s2)) ? fwd_val_q : cur_rd_q;

	always_comb begin
		next_state   = state_q;
		emit         = 1'b0;
		emit_res.status       = ST_OK;
		emit_res.vertex_id    = '0;
		emit_res.label_start  = '0;
		emit_res.vertex_total = count_q;
		clear_set    = 1'b0;
		load_we      = 1'b0;
		set_built    = 1'b0;
		hist_re      = 1'b0;
		hist_raddr   = pop_item.label;
		ofs_re       = 1'b0;
		ofs_we       = 1'b0;
		ofs_waddr    = pf_prev[OFS_AW-1:0];
		cursor_re    = 1'b0;
		cursor_we    = 1'b0;
		cursor_waddr = pf_prev[LABEL_W-1:0];
		cursor_wdata = run_q;
		sorted_re    = 1'b0;
		sorted_we    = 1'b0;
		ls_re        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (pop_item.op)
						OP_LOAD: begin
							if (!built_q && (count_q == CNT_W'(MAX_VERTICES))) begin
								emit = 1'b1;
								emit_res.status = ST_FULL;
							end else begin
								// a load after a build opens a new set
								clear_set  = built_q;
								hist_re    = 1'b1;
								next_state = S_LOAD;
							end
						end
						OP_LOAD_BAD: begin
							emit = 1'b1;
							emit_res.status = ST_LABEL_RANGE;
						end
						OP_BUILD: begin
							next_state = S_PREFIX;
						end
						OP_READ_ENTRY: begin
							if (!built_q || (CNT_W'(pop_item.position) >= count_q)) begin
								emit = 1'b1;
								emit_res.status = ST_NOT_BUILT;
							end else begin
								sorted_re  = 1'b1;
								next_state = S_READ;
							end
						end
						OP_READ_START: begin
							if (!built_q) begin
								emit = 1'b1;
								emit_res.status = ST_NOT_BUILT;
							end else begin
								ofs_re     = 1'b1;
								next_state = S_READ;
							end
						end
						OP_READ_START_BAD: begin
							emit = 1'b1;
							emit_res.status = built_q ? ST_LABEL_RANGE : ST_NOT_BUILT;
						end
						default: begin
							next_state = S_IDLE;
						end
					endcase
				end
			end
			S_LOAD: begin
				if (out_free) begin
					emit    = 1'b1;
					load_we = 1'b1;
					emit_res.vertex_total = count_q + CNT_W'(1);
					next_state = S_IDLE;
				end
			end
			S_READ: begin
				if (out_free) begin
					emit = 1'b1;
					if (op_q == OP_READ_ENTRY) begin
						emit_res.vertex_id = sorted_rd_q;
					end else begin
						emit_res.label_start = ofs_rd_q;
					end
					next_state = S_IDLE;
				end
			end
			S_PREFIX: begin
				hist_re    = (pf_idx_q < PF_W'(MAX_LABELS));
				hist_raddr = pf_idx_q[LABEL_W-1:0];
				ofs_we     = (pf_idx_q != '0);
				cursor_we  = pf_data;
				if (pf_idx_q == PF_W'(PF_LAST)) begin
					next_state = S_SCATTER;
				end
			end
			S_SCATTER: begin
				ls_re     = (sc_idx_q < count_q);
				cursor_re = vld_s1;
				if (vld_s2) begin
					cursor_we    = 1'b1;
					cursor_waddr = lab_s2;
					cursor_wdata = slot + CNT_W'(1);
					sorted_we    = 1'b1;
				end
				if (!ls_re && !vld_s1 && !vld_s2 && out_free) begin
					emit       = 1'b1;
					set_built  = 1'b1;
					next_state = S_IDLE;
				end
			end
			default: begin
				next_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			built_q    <= 1'b0;
			hist_vld_q <= '0;
			pf_idx_q   <= '0;
			sc_idx_q   <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			fwd_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= next_state;
			if (take) begin
				op_q  <= pop_item.op;
				lab_q <= pop_item.label;
			end
			if (clear_set) begin
				hist_vld_q <= '0;
				count_q    <= '0;
				built_q    <= 1'b0;
			end
			if (load_we) begin
				hist_vld_q[lab_q] <= 1'b1;
				count_q           <= count_q + CNT_W'(1);
			end
			if (set_built) begin
				built_q <= 1'b1;
			end
			// prefix sweep: read one histogram entry a cycle, sum one behind
			if (take && (pop_item.op == OP_BUILD)) begin
				pf_idx_q <= '0;
				run_q    <= '0;
			end else if (state_q == S_PREFIX) begin
				pf_idx_q <= pf_idx_q + PF_W'(1);
				if (pf_data) begin
					run_q <= run_q + pf_h;
				end
			end
			// scatter pipeline: label read, cursor read, slot write
			if (state_q == S_PREFIX) begin
				sc_idx_q <= '0;
			end else if (ls_re) begin
				sc_idx_q <= sc_idx_q + CNT_W'(1);
			end
			vld_s1    <= ls_re;
			id_s1     <= sc_idx_q[POS_W-1:0];
			vld_s2    <= vld_s1;
			id_s2     <= id_s1;
			lab_s2    <= ls_rd_q;
			fwd_vld_q <= vld_s2;
			fwd_lab_q <= lab_s2;
			fwd_val_q <= slot + CNT_W'(1);
			// result register: hold while stalled, drop once taken
			if (emit) begin
				out_vld_q <= 1'b1;
				out_res_q <= emit_res;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			label_store_mem[count_q[POS_W-1:0]] <= lab_q;
		end
		if (ls_re) begin
			ls_rd_q <= label_store_mem[sc_idx_q[POS_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			hist_mem[lab_q] <= hist_new;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[hist_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ofs_we) begin
			ofs_mem[ofs_waddr] <= run_q;
		end
		if (ofs_re) begin
			ofs_rd_q <= ofs_mem[OFS_AW'(pop_item.label)];
		end
	end

	always_ff @(posedge clk) begin
		if (cursor_we) begin
			cursor_mem[cursor_waddr] <= cursor_wdata;
		end
		if (cursor_re) begin
			cur_rd_q <= cursor_mem[ls_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (sorted_we) begin
			sorted_mem[slot[POS_W-1:0]] <= id_s2;
		end
		if (sorted_re) begin
			sorted_rd_q <= sorted_mem[pop_item.position];
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond store depth");

	a_prefix_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREFIX && pf_idx_q == PF_W'(PF_LAST)) |-> (run_q == count_q))
		else $error("histogram sum differs from vertex count");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCATTER && vld_s2) |-> (slot < count_q))
		else $error("scatter slot beyond vertex count");

	a_read_built: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> built_q)
		else $error("lookup issued without a built index");

	a_load_set_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> !built_q)
		else $error("load in progress while index marked built");

endmodule

`default_nettype wire

FILE: hdl/label_counting_sort_index.sv
// Top level of the label counting-sort index: front end, beat queue and back end.
//
// Load beats append one vertex each (its ID is its load order) and count its label;
// a build beat turns the label histogram into start offsets and scatters every
// vertex ID, in load order, into its label's group, so equal labels keep load order;
// read beats return the vertex at a sorted position or the first position of a label.
// The front end accepts one beat a cycle into a two-entry queue while it has room and
// classifies it against the label count register; the back end works on one beat at a
// time and parks each result in an output register. It takes the next beat in the cycle
// the previous result leaves; a stalled result holds the back end, and further beats
// wait in the queue until it fills. In the back end a load reads the histogram, then
// updates it; a read entry or label start makes one memory read, and a rejected beat
// gets its result straight from the idle state. A build runs a prefix sweep over the
// histogram memory, one label a cycle, then moves one vertex a cycle through a
// three-stage scatter pipeline. The histogram has a valid bit per label, so no
// clearing pass runs after reset or a new set.
// Write the label count only while the block is idle.
`default_nettype none

module label_counting_sort_index (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [lcsi_pkg::KIND_W-1:0]   kind,
	input  logic [lcsi_pkg::LABEL_W-1:0]  label,
	input  logic [lcsi_pkg::POS_W-1:0]    position,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [lcsi_pkg::STATUS_W-1:0] status,
	output logic [lcsi_pkg::POS_W-1:0]    vertex_id,
	output logic [lcsi_pkg::CNT_W-1:0]    label_start,
	output logic [lcsi_pkg::CNT_W-1:0]    vertex_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lcsi_pkg::LCNT_W-1:0]   label_count
);
	import lcsi_pkg::*;

	// front to queue
	logic         push_valid;
	logic         push_ready;
	lcsi_item_t   push_item;
	// queue to back
	logic         pop_valid;
	logic         pop_ready;
	lcsi_item_t   pop_item;
	// result beat
	lcsi_result_t result;

	lcsi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.kind        (kind),
		.label       (label),
		.position    (position),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.label_count (label_count),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_item   (push_item)
	);

	// decouple acceptance from the multi-cycle back end
	lcsi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	lcsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// split the result beat onto its field ports
	assign status       = result.status;
	assign vertex_id    = result.vertex_id;
	assign label_start  = result.label_start;
	assign vertex_total = result.vertex_total;

endmodule

`default_nettype wire
